// ===== src/ece_pkg.sv =====
// Shared types, constants and arithmetic helpers of the easing curve evaluator.
`timescale 1ns / 1ps
package ece_pkg;

  // Q2.30 working format
  localparam int unsigned QB = 30;
  localparam logic [30:0] Q_ONE = 31'h4000_0000;
  localparam logic [32:0] HALF_PI_Q = 33'd1686629713;
  localparam logic [32:0] LN2_Q = 33'd744261118;
  // (2^35 + 1) / 3, exact floor of n / 3 for n below 2^35
  localparam logic [34:0] DIV3_M = 35'h2_AAAA_AAAB;
  localparam int unsigned DIV3_SH = 35;
  localparam int unsigned NSTAGE = 29;

  typedef enum logic [2:0] {
    OP_SINE, OP_QUAD, OP_CUBIC, OP_QUART, OP_QUINT, OP_ELASTIC, OP_BOUNCE, OP_LINEAR
  } ece_op_e;

  typedef enum logic [1:0] {DIR_IN, DIR_OUT, DIR_INOUT, DIR_INOUT_ALT} ece_dir_e;

  // how the in-curve value v turns into 2*y
  typedef enum logic [1:0] {SEL_IN, SEL_OUT, SEL_HALF_IN, SEL_HALF_OUT} ece_sel_e;

  typedef enum logic [1:0] {CL_NONE, CL_ZERO, CL_ONE} ece_clamp_e;

  typedef struct packed {
    ece_op_e           op;
    ece_dir_e          dir;
    ece_sel_e          sel;
    ece_clamp_e        clamp;
    logic [30:0]       arg;     // in-curve argument
    logic [30:0]       pw;      // running power
    logic [31:0]       bmag;    // bounce parabola offset magnitude
    logic              bsh;     // last bounce segment
    logic [29:0]       badd;
    logic signed [31:0] binc;   // bounce-in value
    logic [34:0]       ph;      // sine phase in turns
    logic [1:0]        quad;
    logic [30:0]       ar;      // reduced angle
    logic [31:0]       a2;
    logic signed [31:0] tc;     // cosine series term
    logic signed [31:0] ts;     // sine series term
    logic [31:0]       mc;
    logic [31:0]       ms;
    logic [3:0]        kint;    // integer part of exp2 argument
    logic [29:0]       fr;
    logic [29:0]       bm;      // |fraction * ln2|
    logic [30:0]       er;      // exp series term
    logic [29:0]       me;
    logic [30:0]       ee;      // 2^-m
    logic signed [31:0] st;     // sine of phase
    logic signed [31:0] el;     // elastic-in value
    logic [17:0]       val;     // raw progress at entry, result at exit
  } ece_item_t;

  // unsigned Q30 product, rounded to nearest, ties up
  function automatic logic [35:0] mulq(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b);
    return 36'((p + (66'd1 << (QB - 1))) >> QB);
  endfunction

  // floor(x / d) through a precomputed reciprocal m = ceil(2^(32+l) / d)
  function automatic logic [31:0] divm(input logic [31:0] x, input logic [33:0] m,
                                       input int unsigned l);
    logic [71:0] p;
    p = 72'(x) * 72'(m);
    return 32'(p >> (32 + l));
  endfunction

endpackage

// ===== src/easing_curve_evaluator.sv =====
// Top level of the easing curve evaluator: stream ports and the stage chain.
//
// Evaluates one easing curve point per word. The input word carries the
// progress t (signed, FRAC_BITS fraction bits) in s_axis_tdata and the curve
// family and direction in s_axis_tuser. The output word carries the eased
// value, same format, in m_axis_tdata. t below 0 gives 0, above 1 gives 1.
// Sine, exp2 and the power curves run through a 29-stage pipeline of
// shared-format Q2.30 arithmetic; the sine and exp2 series iterations set
// the depth. A new word is taken every cycle unless a stalled receiver
// has filled every stage.
// The last stage is the output register. A stage advances when it is empty
// or the stage after it advances, so a stalled receiver holds the result
// in place while bubbles further up still fill; s_axis_tready drops only
// when every stage holds a word. Reset empties all stages at once; no
// state survives between words.
`timescale 1ns / 1ps
module easing_curve_evaluator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] progress
  input  logic [4:0]  s_axis_tuser,   // [2:0] operation, [4:3] direction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [17:0] eased_value
);
  import ece_pkg::*;

  ece_item_t           item [0:NSTAGE];
  logic [NSTAGE:0]     vld;
  logic [NSTAGE+1:1]   ld;

  // first stage decodes the raw word; progress rides in the val field
  always_comb begin
    item[0]     = '0;
    item[0].op  = ece_op_e'(s_axis_tuser[2:0]);
    item[0].dir = ece_dir_e'(s_axis_tuser[4:3]);
    item[0].val = s_axis_tdata[17:0];
  end
  assign vld[0] = s_axis_tvalid;
  assign ld[NSTAGE+1] = m_axis_tready;

  for (genvar k = 1; k <= NSTAGE; k++) begin : g_stage
    assign ld[k] = !vld[k] || ld[k+1];
    ece_stage #(
      .K        (k),
      .FRAC_BITS(FRAC_BITS)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ld_i  (ld[k]),
      .vld_i (vld[k-1]),
      .item_i(item[k-1]),
      .vld_o (vld[k]),
      .item_o(item[k])
    );
  end

  assign s_axis_tready = ld[1];
  assign m_axis_tvalid = vld[NSTAGE];
  assign m_axis_tdata  = {6'b0, item[NSTAGE].val};

endmodule

// ===== src/ece_stage.sv =====
// One register stage of the evaluator pipeline; K selects the work done here.
`timescale 1ns / 1ps
module ece_stage #(
  parameter int unsigned K = 1,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  logic               vld_i,
  input  ece_pkg::ece_item_t item_i,
  output logic               vld_o,
  output ece_pkg::ece_item_t item_o
);
  import ece_pkg::*;

  // series iteration indexes
  localparam int unsigned TN = (K >= 5 && K <= 20) ? 8 - (K - 5) / 2 : 1;
  localparam int unsigned EI = (K >= 3 && K <= 26) ? 12 - (K - 3) / 2 : 1;
  localparam int unsigned DC = (2 * TN - 1) * 2 * TN;
  localparam int unsigned DS = 2 * TN * (2 * TN + 1);
  localparam int unsigned LC = $clog2(DC);
  localparam int unsigned LS = $clog2(DS);
  localparam int unsigned LE = $clog2(EI);
  localparam longint unsigned MC = ((64'd1 << (32 + LC)) + DC - 1) / DC;
  localparam longint unsigned MS = ((64'd1 << (32 + LS)) + DS - 1) / DS;
  localparam longint unsigned ME = ((64'd1 << (32 + LE)) + EI - 1) / EI;
  localparam bit TRIG_MUL = (K >= 5 && K <= 19 && (K % 2) == 1);
  localparam bit TRIG_DIV = (K >= 6 && K <= 20 && (K % 2) == 0);
  localparam bit EXP_MUL  = (K >= 3 && K <= 25 && (K % 2) == 1);
  localparam bit EXP_DIV  = (K >= 4 && K <= 26 && (K % 2) == 0);
  localparam int unsigned RS = 31 - FRAC_BITS;

  logic               vld_q;
  ece_item_t          item_q, item_d;

  always_comb begin
    logic signed [31:0] t32;
    logic [31:0]        xw;
    logic [30:0]        x, xb;
    logic [35:0]        u;
    logic signed [36:0] d;
    logic [34:0]        n3, em;
    logic [69:0]        qp;
    logic [63:0]        s2;
    logic [31:0]        sq;
    logic [35:0]        m;
    logic signed [31:0] am;
    logic signed [33:0] v;
    logic signed [35:0] y2;
    logic [41:0]        yb, rr;
    item_d = item_i;
    t32 = '0; xw = '0; x = '0; xb = '0; u = '0; d = '0; n3 = '0; em = '0;
    qp = '0; s2 = '0; sq = '0; m = '0; am = '0; v = '0; y2 = '0; yb = '0; rr = '0;

    if (K == 1) begin
      t32 = 32'(signed'(item_i.val));
      if (t32 < 0) item_d.clamp = CL_ZERO;
      else if (t32 > (32'sd1 <<< FRAC_BITS)) item_d.clamp = CL_ONE;
      else item_d.clamp = CL_NONE;
      xw = 32'(t32) << (QB - FRAC_BITS);
      x = xw[30:0];
      case (item_i.dir)
        DIR_IN: begin
          item_d.arg = x;
          item_d.sel = SEL_IN;
        end
        DIR_OUT: begin
          item_d.arg = Q_ONE - x;
          item_d.sel = SEL_OUT;
        end
        default: begin
          if (x < (Q_ONE >> 1)) begin
            item_d.arg = {x[29:0], 1'b0};
            item_d.sel = SEL_HALF_IN;
          end else begin
            item_d.arg = 31'(32'h8000_0000 - {x, 1'b0});
            item_d.sel = SEL_HALF_OUT;
          end
        end
      endcase
      // bounce-out is taken at 1 - arg
      xb = Q_ONE - item_d.arg;
      u = 36'(xb) * 36'd11;
      item_d.bsh = 1'b0;
      if (u[35:30] < 6'd4) begin
        d = 37'(u);
        item_d.badd = 30'h0;
      end else if (u[35:30] < 6'd8) begin
        d = signed'(37'(u) - (37'd6 << QB));
        item_d.badd = 30'h3000_0000;
      end else if (u[35:30] < 6'd10) begin
        d = signed'(37'(u) - (37'd9 << QB));
        item_d.badd = 30'h3C00_0000;
      end else begin
        d = signed'(37'(xb) * 37'd22 - (37'd21 << QB));
        item_d.badd = 30'h3F00_0000;
        item_d.bsh = 1'b1;
      end
      item_d.bmag = (d < 0) ? 32'(-d) : 32'(d);
      n3 = 35'(item_d.arg) * 35'd10 + 35'h5000_0000 + 35'd1;
      item_d.ph = (item_i.op == OP_ELASTIC) ? n3
                  : 35'(item_d.arg >> 2) + 35'h1000_0000;
      em = 35'h2_8000_0000 - 35'(item_d.arg) * 35'd10;
      item_d.kint = em[33:30];
      item_d.fr = em[29:0];
      item_d.pw = item_d.arg;
      item_d.er = Q_ONE;
      item_d.tc = 32'(Q_ONE);
      item_d.ts = 32'(Q_ONE);
    end

    if (K == 2) begin
      if (item_i.op == OP_ELASTIC) begin
        qp = 70'(item_i.ph) * 70'(DIV3_M);
        item_d.ph = 35'(qp >> DIV3_SH);
      end
      item_d.bm = 30'(mulq(33'(item_i.fr), LN2_Q));
      s2 = 64'(item_i.bmag) * 64'(item_i.bmag);
      sq = item_i.bsh ? 32'((s2 + (64'd1 << 35)) >> 36) : 32'((s2 + (64'd1 << 33)) >> 34);
      item_d.binc = signed'(32'(Q_ONE) - 32'(item_i.badd) - sq);
    end

    if (K == 3) begin
      item_d.quad = item_i.ph[29:28];
      item_d.ar = 31'(mulq(33'({item_i.ph[27:0], 2'b00}), HALF_PI_Q));
    end

    if (K == 4) item_d.a2 = 32'(mulq(33'(item_i.ar), 33'(item_i.ar)));

    // powers: multiply while the count stays within the exponent
    if (K >= 2 && K <= 5) begin
      if (32'(item_i.op) >= K - 1)
        item_d.pw = 31'(mulq(33'(item_i.pw), 33'(item_i.arg)));
    end

    if (TRIG_MUL) begin
      item_d.mc = 32'(mulq(33'(item_i.a2), 33'(item_i.tc[30:0])));
      if (TN <= 7) item_d.ms = 32'(mulq(33'(item_i.a2), 33'(item_i.ts[30:0])));
    end
    if (TRIG_DIV) begin
      item_d.tc = signed'(32'(Q_ONE) - divm(item_i.mc, 34'(MC), LC));
      if (TN <= 7) item_d.ts = signed'(32'(Q_ONE) - divm(item_i.ms, 34'(MS), LS));
    end

    if (EXP_MUL) item_d.me = 30'(mulq(33'(item_i.bm), 33'(item_i.er)));
    if (EXP_DIV) item_d.er = 31'(32'(Q_ONE) - divm(32'(item_i.me), 34'(ME), LE));

    if (K == 21) begin
      m = mulq(33'(item_i.ar), 33'(item_i.ts[30:0]));
      case (item_i.quad)
        2'd0:    item_d.st = signed'(32'(m));
        2'd1:    item_d.st = item_i.tc;
        2'd2:    item_d.st = -signed'(32'(m));
        default: item_d.st = -item_i.tc;
      endcase
    end

    if (K == 27) begin
      if (item_i.kint == 4'd0) item_d.ee = item_i.er;
      else item_d.ee = ((item_i.er >> (item_i.kint - 4'd1)) + 31'd1) >> 1;
    end

    if (K == 28) begin
      am = (item_i.st < 0) ? -item_i.st : item_i.st;
      m = mulq(33'(item_i.ee), 33'(am));
      item_d.el = (item_i.st < 0) ? signed'(32'(m)) : -signed'(32'(m));
    end

    if (K == 29) begin
      case (item_i.op)
        OP_SINE:    v = 34'(Q_ONE) - 34'(item_i.st);
        OP_QUAD, OP_CUBIC, OP_QUART, OP_QUINT: v = 34'(item_i.pw);
        OP_ELASTIC: v = 34'(item_i.el);
        OP_BOUNCE:  v = 34'(item_i.binc);
        default:    v = 34'(item_i.arg);
      endcase
      case (item_i.sel)
        SEL_IN:      y2 = 36'(v) <<< 1;
        SEL_OUT:     y2 = (36'(Q_ONE) - 36'(v)) <<< 1;
        SEL_HALF_IN: y2 = 36'(v);
        default:     y2 = 36'(signed'(36'h8000_0000)) - 36'(v);
      endcase
      yb = 42'(y2) + (42'd1 << 40);
      rr = ((yb >> (RS - 1)) + 42'd1) >> 1;
      case (item_i.clamp)
        CL_ZERO: item_d.val = '0;
        CL_ONE:  item_d.val = 18'(42'd1 << FRAC_BITS);
        default: item_d.val = 18'(rr - (42'd1 << (40 - RS)));
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ld_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i && vld_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== src/ece_checker.sv =====
// Port-level checks of the easing curve evaluator, bound to the top level.
`timescale 1ns / 1ps
module ece_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [4:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // hold a waiting input word
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("waiting input word changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // an empty output stage lets the whole chain advance
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'b0)
    else $error("output padding not zero");

endmodule

bind easing_curve_evaluator ece_checker u_ece_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
